// ===== rtl/core/tlc_pkg.sv =====
// Shared types and character codes for the two-line text console.
package tlc_pkg;

    localparam logic [7:0] CHAR_FF       = 8'h0C;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_NL       = 8'h0A;
    localparam logic [7:0] CHAR_BS       = 8'h08;
    localparam logic [7:0] CHAR_BLANK    = 8'h20;
    localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI = 8'h7E;

    localparam int CELL_COL_W = 4;

    // Per-cycle commands from the controller to the screen memory.
    typedef struct packed {
        logic re;
        logic we;
        logic blank;
        logic clr_all;
        logic clr_bank_en;
        logic clr_bank;
    } mem_ctl_t;

endpackage

// ===== rtl/core/two_line_text_console_core.sv =====
// Two-line scrolling text console: character decode, cursor and screen refresh.
//
//   channel | signals                                      | dir
//   --------+----------------------------------------------+-----
//   char    | char_valid, char_ready, char_code[7:0]       | in
//   cell    | cell_valid, cell_ready, cell_row, cell_col,  | out
//           | cell_char[7:0], last_cell                    |
//
// A request that changes the screen updates the memory and cursor while idle, then
// refreshes the whole screen, one memory read per cell.
// Carriage return, backspace at column zero and other dropped bytes are taken without a refresh.
// Scrolling swaps the screen banks; blanking clears valid bits.
// Reset blanks the screen and homes the cursor; no clearing pass is needed.
// A stalled cell holds in the memory read register; no read issues until it is taken.
module two_line_text_console_core
    import tlc_pkg::*;
#(
    parameter int COLUMNS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_ready,
    input  logic [7:0]            char_code,
    output logic                  cell_valid,
    input  logic                  cell_ready,
    output logic                  cell_row,
    output logic [CELL_COL_W-1:0] cell_col,
    output logic [7:0]            cell_char,
    output logic                  last_cell
);

    localparam int CW = $clog2(COLUMNS);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    state_t          state_reg, state_next;
    logic            cursor_row_reg, cursor_row_next;
    logic [CW-1:0]   cursor_col_reg, cursor_col_next;
    logic            top_sel_reg, top_sel_next;
    logic            cnt_row_reg, cnt_row_next;
    logic [CW-1:0]   cnt_col_reg, cnt_col_next;
    logic            cell_valid_reg, cell_valid_next;
    logic            cell_row_reg, cell_row_next;
    logic [CW-1:0]   cell_col_reg, cell_col_next;
    logic            last_cell_reg, last_cell_next;

    mem_ctl_t        ctl;
    logic            wr_bank;
    logic [CW-1:0]   wr_col;
    logic            rd_bank;
    logic            cur_bank;
    logic            new_line;
    logic            issue;
    logic            cnt_last;
    logic [CW+CELL_COL_W-1:0] col_ext;

    assign cur_bank = cursor_row_reg ? ~top_sel_reg : top_sel_reg;
    assign rd_bank  = cnt_row_reg ? ~top_sel_reg : top_sel_reg;
    assign cnt_last = cnt_row_reg && (cnt_col_reg == LAST_COL);
    assign issue    = (state_reg == ST_EMIT) && (!cell_valid_reg || cell_ready);

    always_comb
    begin
        state_next      = state_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        top_sel_next    = top_sel_reg;
        cnt_row_next    = cnt_row_reg;
        cnt_col_next    = cnt_col_reg;
        cell_row_next   = cell_row_reg;
        cell_col_next   = cell_col_reg;
        last_cell_next  = last_cell_reg;
        ctl             = '0;
        wr_bank         = cur_bank;
        wr_col          = cursor_col_reg;
        new_line        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_row_next = 1'b0;
                cnt_col_next = '0;
                if (char_valid)
                begin
                    priority if (char_code == CHAR_FF)
                    begin
                        ctl.clr_all     = 1'b1;
                        cursor_row_next = 1'b0;
                        cursor_col_next = '0;
                        state_next      = ST_EMIT;
                    end
                    else if (char_code == CHAR_NL)
                    begin
                        new_line = 1'b1;
                    end
                    else if (char_code == CHAR_BS)
                    begin
                        if (cursor_col_reg != '0)
                        begin
                            cursor_col_next = cursor_col_reg - 1'b1;
                            wr_col          = cursor_col_reg - 1'b1;
                            ctl.blank       = 1'b1;
                            state_next      = ST_EMIT;
                        end
                    end
                    else if (char_code >= CHAR_PRINT_LO && char_code <= CHAR_PRINT_HI)
                    begin
                        ctl.we = 1'b1;
                        if (cursor_col_reg == LAST_COL)
                        begin
                            new_line = 1'b1;
                        end
                        else
                        begin
                            cursor_col_next = cursor_col_reg + 1'b1;
                        end
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end

                    // From the bottom row a new line swaps banks; the new bottom bank is blanked either way.
                    if (new_line)
                    begin
                        top_sel_next    = cursor_row_reg ? ~top_sel_reg : top_sel_reg;
                        ctl.clr_bank_en = 1'b1;
                        ctl.clr_bank    = ~top_sel_next;
                        cursor_row_next = 1'b1;
                        cursor_col_next = '0;
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    ctl.re         = 1'b1;
                    cell_row_next  = cnt_row_reg;
                    cell_col_next  = cnt_col_reg;
                    last_cell_next = cnt_last;
                    if (cnt_col_reg == LAST_COL)
                    begin
                        cnt_col_next = '0;
                        cnt_row_next = 1'b1;
                    end
                    else
                    begin
                        cnt_col_next = cnt_col_reg + 1'b1;
                    end
                    if (cnt_last)
                    begin
                        cnt_row_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (issue)
        begin
            cell_valid_next = 1'b1;
        end
        else if (cell_ready)
        begin
            cell_valid_next = 1'b0;
        end
        else
        begin
            cell_valid_next = cell_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_row_reg <= 1'b0;
            cursor_col_reg <= '0;
            top_sel_reg    <= 1'b0;
            cnt_row_reg    <= 1'b0;
            cnt_col_reg    <= '0;
            cell_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            top_sel_reg    <= top_sel_next;
            cnt_row_reg    <= cnt_row_next;
            cnt_col_reg    <= cnt_col_next;
            cell_valid_reg <= cell_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_row_reg  <= cell_row_next;
        cell_col_reg  <= cell_col_next;
        last_cell_reg <= last_cell_next;
    end

    tlc_screen_mem #(
        .COLUMNS (COLUMNS),
        .CW      (CW)
    ) u_screen_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .wr_bank (wr_bank),
        .wr_col  (wr_col),
        .wr_data (char_code),
        .rd_bank (rd_bank),
        .rd_col  (cnt_col_reg),
        .rd_char (cell_char)
    );

    assign char_ready = (state_reg == ST_IDLE);
    assign cell_valid = cell_valid_reg;
    assign cell_row   = cell_row_reg;
    assign col_ext    = {{CELL_COL_W{1'b0}}, cell_col_reg};
    assign cell_col   = col_ext[CELL_COL_W-1:0];
    assign last_cell  = last_cell_reg;

`ifndef NO_ASSERTIONS
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_col_reg <= LAST_COL)
        else $error("cursor column beyond line end");

    a_last_on_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && last_cell) |-> (cell_row && cell_col_reg == LAST_COL))
        else $error("last cell flagged off the final cell");

    a_refresh_done: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && cnt_last) |=> (char_ready && cnt_row_reg == 1'b0))
        else $error("refresh did not return to idle after final cell");
`endif

endmodule

// ===== rtl/core/tlc_screen_mem.sv =====
// Screen memory: two banks of character cells with per-cell valid bits.
module tlc_screen_mem
    import tlc_pkg::*;
#(
    parameter int COLUMNS = 16,
    parameter int CW      = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mem_ctl_t      ctl,
    input  logic          wr_bank,
    input  logic [CW-1:0] wr_col,
    input  logic [7:0]    wr_data,
    input  logic          rd_bank,
    input  logic [CW-1:0] rd_col,
    output logic [7:0]    rd_char
);

    logic [7:0]                 mem [0:1][0:COLUMNS-1];
    logic [1:0][COLUMNS-1:0]    valid_reg;
    logic [1:0][COLUMNS-1:0]    valid_next;
    logic [7:0]                 rd_data_reg;
    logic                       rd_valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.we)
        begin
            valid_next[wr_bank][wr_col] = 1'b1;
        end
        if (ctl.blank)
        begin
            valid_next[wr_bank][wr_col] = 1'b0;
        end
        if (ctl.clr_bank_en)
        begin
            valid_next[ctl.clr_bank] = '0;
        end
        if (ctl.clr_all)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[wr_bank][wr_col] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rd_data_reg  <= mem[rd_bank][rd_col];
            rd_valid_reg <= valid_reg[rd_bank][rd_col];
        end
    end

    assign rd_char = rd_valid_reg ? rd_data_reg : CHAR_BLANK;

`ifndef NO_ASSERTIONS
    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.re && (ctl.we || ctl.blank || ctl.clr_all || ctl.clr_bank_en)))
        else $error("screen read overlaps an update");

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr_all |=> (valid_reg == '0))
        else $error("clear did not blank the screen");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.we && !ctl.clr_all && !(ctl.clr_bank_en && ctl.clr_bank == wr_bank))
        |=> valid_reg[$past(wr_bank)][$past(wr_col)])
        else $error("written cell not marked valid");
`endif

endmodule

// ===== tb/two_line_text_console_checker.sv =====
// Checker for the two-line text console: screen prediction per request and cell comparison.
module two_line_text_console_checker
    import tlc_pkg::*;
#(
    parameter int COLUMNS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    input  logic                  char_ready,
    input  logic [7:0]            char_code,
    input  logic                  cell_valid,
    input  logic                  cell_ready,
    input  logic                  cell_row,
    input  logic [CELL_COL_W-1:0] cell_col,
    input  logic [7:0]            cell_char,
    input  logic                  last_cell,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic                  row;
        logic [CELL_COL_W-1:0] col;
        logic [7:0]            chr;
        logic                  last;
    } screen_cell_t;

    logic [7:0]   top_line [COLUMNS];
    logic [7:0]   bottom_line [COLUMNS];
    logic         cur_row;
    logic [4:0]   cur_col;
    screen_cell_t refresh_q [$];

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
        if (fail_count < 40)
        begin
            $display("%0t: cell %s mismatch, got %h expected %h", $realtime, field, got, want);
        end
        fail_count++;
    endtask

    task automatic clear_screen();
        foreach (top_line[i])
        begin
            top_line[i]    = CHAR_BLANK;
            bottom_line[i] = CHAR_BLANK;
        end
        cur_row = 1'b0;
        cur_col = '0;
    endtask

    task automatic move_to_next_line();
        if (cur_row)
        begin
            top_line = bottom_line;
        end
        foreach (bottom_line[i])
        begin
            bottom_line[i] = CHAR_BLANK;
        end
        cur_row = 1'b1;
        cur_col = '0;
    endtask

    task automatic apply_char(input logic [7:0] c, output bit refresh);
        refresh = 1'b1;
        if (c == CHAR_FF)
        begin
            clear_screen();
        end
        else if (c == CHAR_CR)
        begin
            refresh = 1'b0;
        end
        else if (c == CHAR_NL)
        begin
            move_to_next_line();
        end
        else if (c == CHAR_BS)
        begin
            if (cur_col == 0)
            begin
                refresh = 1'b0;
            end
            else
            begin
                cur_col--;
                if (cur_row)
                    bottom_line[cur_col] = CHAR_BLANK;
                else
                    top_line[cur_col] = CHAR_BLANK;
            end
        end
        else if (c < CHAR_PRINT_LO || c > CHAR_PRINT_HI)
        begin
            refresh = 1'b0;
        end
        else
        begin
            if (cur_row)
                bottom_line[cur_col] = c;
            else
                top_line[cur_col] = c;
            cur_col++;
            if (cur_col >= COLUMNS)
            begin
                move_to_next_line();
            end
        end
    endtask

    task automatic queue_refresh();
        screen_cell_t entry;
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < COLUMNS; c++)
            begin
                entry.row  = r[0];
                entry.col  = c[CELL_COL_W-1:0];
                entry.chr  = r[0] ? bottom_line[c] : top_line[c];
                entry.last = (r == 1 && c == COLUMNS - 1);
                refresh_q.push_back(entry);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        screen_cell_t got;
        screen_cell_t want;
        bit           refresh;
        if (!rst_n)
        begin
            clear_screen();
            refresh_q.delete();
        end
        else
        begin
            // cells come from earlier requests, so compare before predicting
            if (cell_valid && cell_ready)
            begin
                got = {cell_row, cell_col, cell_char, last_cell};
                if (refresh_q.size() == 0)
                begin
                    report("with nothing expected", got.chr, got.chr);
                end
                else
                begin
                    want = refresh_q.pop_front();
                    if (got.row !== want.row)
                        report("row", 8'(got.row), 8'(want.row));
                    if (got.col !== want.col)
                        report("col", 8'(got.col), 8'(want.col));
                    if (got.chr !== want.chr)
                        report("char", got.chr, want.chr);
                    if (got.last !== want.last)
                        report("last", 8'(got.last), 8'(want.last));
                end
            end
            if (char_valid && char_ready)
            begin
                apply_char(char_code, refresh);
                if (refresh)
                begin
                    queue_refresh();
                end
            end
        end
        pending = refresh_q.size();
    end

endmodule

// ===== tb/tb_two_line_text_console_core.sv =====
// Testbench top for the two-line text console: clock, reset, request stimulus and verdict.
module tb_two_line_text_console_core;
    import tlc_pkg::*;

    localparam int COLUMNS = 16;
    localparam int ITEM_TARGET = 380;

    localparam logic [7:0] DIRECTED [13] = '{
        CHAR_FF, CHAR_BS, CHAR_PRINT_LO, CHAR_PRINT_HI, CHAR_BS, CHAR_CR,
        8'h00, 8'h1F, 8'h7F, 8'h80, 8'hFF, CHAR_NL, CHAR_NL
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  char_valid = 1'b0;
    logic                  char_ready;
    logic [7:0]            char_code = '0;
    logic                  cell_valid;
    logic                  cell_ready = 1'b0;
    logic                  cell_row;
    logic [CELL_COL_W-1:0] cell_col;
    logic [7:0]            cell_char;
    logic                  last_cell;
    int                    fail_count;
    int                    pending;

    int screen_items = 0;
    bit calm_src = 1'b0;
    bit calm_sink = 1'b0;
    int stall_left = 0;
    int sink_phase_left = 0;

    two_line_text_console_core #(.COLUMNS(COLUMNS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .cell_char  (cell_char),
        .last_cell  (last_cell)
    );

    two_line_text_console_checker #(.COLUMNS(COLUMNS)) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .cell_char  (cell_char),
        .last_cell  (last_cell),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int draw_idle(input bit calm);
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (sink_phase_left == 0)
        begin
            calm_sink       <= ~calm_sink;
            sink_phase_left <= $urandom_range(100, 1500);
        end
        else
        begin
            sink_phase_left <= sink_phase_left - 1;
        end
        if (stall_left != 0)
        begin
            cell_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            cell_ready <= 1'b1;
            stall_left <= draw_idle(calm_sink);
        end
    end

    task automatic send_char(input logic [7:0] code);
        int gap;
        char_valid <= 1'b1;
        char_code  <= code;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        if (code == CHAR_FF || code == CHAR_NL || code == CHAR_BS ||
            (code >= CHAR_PRINT_LO && code <= CHAR_PRINT_HI))
            screen_items++;
        gap = draw_idle(calm_src);
        if (gap != 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
    endfunction

    initial
    begin
        int unsigned r;
        int          src_phase_left;
        src_phase_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_char(DIRECTED[i]);

        while (screen_items < ITEM_TARGET)
        begin
            if (src_phase_left == 0)
            begin
                calm_src       = !calm_src;
                src_phase_left = $urandom_range(10, 60);
            end
            src_phase_left--;
            r = $urandom_range(99);
            if (r < 35)
                repeat ($urandom_range(1, 20)) send_char(printable());
            else if (r < 48)
                send_char(CHAR_NL);
            else if (r < 60)
                send_char(CHAR_BS);
            else if (r < 64)
                send_char(CHAR_FF);
            else if (r < 69)
                send_char(CHAR_CR);
            else if (r < 77)
                send_char(8'($urandom_range(255)));
            else if (r < 83)
                send_char(8'($urandom_range(128, 255)));
            else
                send_char(printable());
        end

        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
